>>> src/ptd_pkg.sv
// Shared types and constants for the trial-division primality tester.
// No dependencies; imported by ptd_rem_unit, ptd_ctrl and the top level.
package ptd_pkg;

  localparam int NUMBER_WIDTH_DEF = 24;  // default width of the tested number
  localparam int IN_W             = 24;  // width of the in_number port
  localparam int FIRST_DIV        = 3;   // first odd trial divisor
  localparam int DIV_STEP         = 2;   // distance between odd divisors

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CHECK  = 3'b010,
    ST_DIVIDE = 3'b100
  } state_t;

  // Status from the remainder unit back to the sequencer.
  typedef struct packed {
    logic done;  // one-cycle pulse: remainder is final
    logic zero;  // remainder is zero (valid with done)
  } rem_stat_t;

endpackage

>>> src/ptd_rem_unit.sv
// Bit-serial restoring remainder unit: one shift-compare-subtract per cycle.
// Depends on ptd_pkg (rem_stat_t).
module ptd_rem_unit #(
  parameter int NUMBER_WIDTH = ptd_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  logic [NUMBER_WIDTH-1:0] dividend,
  input  logic [NUMBER_WIDTH-1:0] divisor,
  output ptd_pkg::rem_stat_t      stat
);
  import ptd_pkg::*;

  localparam int W  = NUMBER_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvd_r, dvd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;

  // Bring down the next dividend bit next to the partial remainder.
  assign trial = {rem_r, dvd_r[W-1]};

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (go) begin
      rem_nxt = '0;
      dvd_nxt = dividend;
      cnt_nxt = CW'(W);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = W'(trial);
      end
      dvd_nxt  = {dvd_r[W-2:0], 1'b0};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule

>>> src/ptd_ctrl.sv
// Sequencer: special cases, odd divisor and its square, result register.
// Depends on ptd_pkg (state_t, rem_stat_t, divisor constants).
module ptd_ctrl #(
  parameter int NUMBER_WIDTH = ptd_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [NUMBER_WIDTH-1:0] number,
  output logic                    busy,
  output logic                    out_valid,
  output logic                    out_is_prime,
  output logic                    rem_go,
  output logic [NUMBER_WIDTH-1:0] rem_dividend,
  output logic [NUMBER_WIDTH-1:0] rem_divisor,
  input  ptd_pkg::rem_stat_t      rem_stat
);
  import ptd_pkg::*;

  localparam int W    = NUMBER_WIDTH;
  localparam int SQ_W = W + 1;
  localparam int SQ0  = FIRST_DIV * FIRST_DIV;

  state_t          state_r, state_nxt;
  logic [W-1:0]    n_r, n_nxt;
  logic [W-1:0]    d_r, d_nxt;
  logic [SQ_W-1:0] sq_r, sq_nxt;
  logic            valid_r, valid_nxt;
  logic            prime_r, prime_nxt;
  logic            go;

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    valid_nxt = 1'b0;
    prime_nxt = prime_r;
    go        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (number[W-1:1] == '0) begin
            // zero and one
            valid_nxt = 1'b1;
            prime_nxt = 1'b0;
          end else if (number == W'(DIV_STEP)) begin
            valid_nxt = 1'b1;
            prime_nxt = 1'b1;
          end else if (!number[0]) begin
            valid_nxt = 1'b1;
            prime_nxt = 1'b0;
          end else begin
            n_nxt     = number;
            d_nxt     = W'(FIRST_DIV);
            sq_nxt    = SQ_W'(SQ0);
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_r > {1'b0, n_r}) begin
          // no divisor up to the square root: prime
          valid_nxt = 1'b1;
          prime_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          go        = 1'b1;
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (rem_stat.done) begin
          if (rem_stat.zero) begin
            valid_nxt = 1'b1;
            prime_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            // advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4
            d_nxt     = d_r + W'(DIV_STEP);
            sq_nxt    = sq_r + SQ_W'({d_r, 2'b00}) + SQ_W'(2 * DIV_STEP);
            state_nxt = ST_CHECK;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    prime_r <= prime_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = valid_r;
  assign out_is_prime = prime_r;
  assign rem_go       = go;
  assign rem_dividend = n_r;
  assign rem_divisor  = d_r;

endmodule

>>> src/prime_test_trial_division.sv
// Trial-division primality tester.
//
// Usage: drive in_number and raise start while busy is low; the beat is
// taken at that clock edge. Exactly one result beat follows: out_valid is
// high for one cycle with out_is_prime (1 = prime). The receiver cannot
// stall; the result is taken in the cycle it is shown. busy stays high
// while a number is being worked on and start is ignored meanwhile.
//
// Only the low NUMBER_WIDTH bits of in_number are tested. Zero, one and
// even numbers, and two, are decided at once: the result shows in the
// cycle after the accepting edge. An odd number is divided by 3, 5, 7, ...
// while the divisor squared does not exceed it, stopping at the first
// zero remainder. Each divisor is tried by the bit-serial remainder unit
// (one bit per cycle) while the sequencer waits for its done pulse; the
// worst case is a prime near 2^24, with about 2047 divisors at width 24.
// Only one number is worked on at a time; no new start is taken before
// its result, and the next start is taken in the cycle the result
// shows. Reset (synchronous, rst_n low) returns to idle and drops any
// number in progress; no result appears for it.
module prime_test_trial_division #(
  parameter int NUMBER_WIDTH = ptd_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [ptd_pkg::IN_W-1:0] in_number,
  output logic                     out_valid,
  output logic                     out_is_prime
);
  import ptd_pkg::*;

  logic [NUMBER_WIDTH-1:0] number;
  logic                    rem_go;
  logic [NUMBER_WIDTH-1:0] rem_dividend;
  logic [NUMBER_WIDTH-1:0] rem_divisor;
  rem_stat_t               rem_stat;

  // Fit the input field to the working width: drop or zero-fill high bits.
  generate
    if (NUMBER_WIDTH >= IN_W) begin : g_widen
      assign number = NUMBER_WIDTH'(in_number);
    end else begin : g_narrow
      assign number = in_number[NUMBER_WIDTH-1:0];
    end
  endgenerate

  ptd_ctrl #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .number      (number),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_is_prime(out_is_prime),
    .rem_go      (rem_go),
    .rem_dividend(rem_dividend),
    .rem_divisor (rem_divisor),
    .rem_stat    (rem_stat)
  );

  ptd_rem_unit #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (rem_go),
    .dividend(rem_dividend),
    .divisor (rem_divisor),
    .stat    (rem_stat)
  );

endmodule

>>> bench/prime_test_trial_division_tb.sv
`timescale 1ns / 1ps
// Testbench for prime_test_trial_division: directed and random numbers, each
// verdict checked against a trial-division predictor kept in this file.
// Depends on ptd_pkg and the prime_test_trial_division RTL.
module prime_test_trial_division_tb;
  import ptd_pkg::*;

  typedef struct {
    logic [IN_W-1:0] number;
    logic            is_prime;
  } verdict_t;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            start     = 1'b0;
  logic [IN_W-1:0] in_number = '0;
  logic            busy;
  logic            out_valid;
  logic            out_is_prime;

  verdict_t pending_verdicts[$];
  int       verdict_errors = 0;
  int       idle_pct       = 0;

  prime_test_trial_division DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_number   (in_number),
    .out_valid   (out_valid),
    .out_is_prime(out_is_prime)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic is_prime_by_division(input logic [IN_W-1:0] raw);
    logic [63:0] n;
    logic [63:0] d;
    n = 64'(raw) & ((64'd1 << NUMBER_WIDTH_DEF) - 64'd1);
    if (n < 64'd2) return 1'b0;
    if (n == 64'd2) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    for (d = FIRST_DIV; d * d <= n; d += DIV_STEP) begin
      if (n % d == 64'd0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    verdict_errors++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Hold start high until a rising edge sees busy low; that edge takes the beat.
  task automatic send_number(input logic [IN_W-1:0] n);
    verdict_t v;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    in_number <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
    v.number   = n;
    v.is_prime = is_prime_by_division(n);
    pending_verdicts.push_back(v);
  endtask

  task automatic drain_verdicts();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  // Mostly small numbers keep the run short; a share of full-width ones
  // toggles every bit. Favor odd values, since only they reach the divider.
  function automatic logic [IN_W-1:0] pick_number();
    logic [IN_W-1:0] n;
    int              r;
    r = $urandom_range(99);
    if (r < 60) n = IN_W'($urandom_range(4095));
    else if (r < 80) n = IN_W'($urandom_range(65535));
    else n = IN_W'($urandom);
    if ($urandom_range(3) != 0) n[0] = 1'b1;
    return n;
  endfunction

  always @(posedge clk) begin : check_verdicts
    verdict_t v;
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending, is_prime=%0b",
                                  out_is_prime));
      end else begin
        v = pending_verdicts.pop_front();
        if (out_is_prime !== v.is_prime)
          report_mismatch($sformatf("number %0d: is_prime=%0b, want %0b",
                                    v.number, out_is_prime, v.is_prime));
      end
    end
  end

  task automatic test_special_numbers();
    logic [IN_W-1:0] numbers[$];
    numbers = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd9, 24'd15, 24'd25,
                24'd49, 24'd121, 24'd65521, 24'h555555, 24'h800000, 24'h800001,
                24'd16752649, 24'd16777213, 24'd16777214, 24'd16777215};
    idle_pct = 0;
    foreach (numbers[i]) send_number(numbers[i]);
    drain_verdicts();
  endtask

  // Zero, one, two and even numbers answer at once; run them back to back.
  task automatic test_fast_path();
    logic [IN_W-1:0] n;
    idle_pct = 0;
    for (int i = 0; i < 10; i++) begin
      n = IN_W'($urandom);
      n[0] = 1'b0;
      if (i < 3) n = IN_W'(i);
      send_number(n);
    end
    drain_verdicts();
  endtask

  task automatic test_random_numbers(input int count, input int pct);
    idle_pct = pct;
    repeat (count) send_number(pick_number());
    drain_verdicts();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_numbers();
    test_fast_path();
    test_random_numbers(40, 0);
    test_random_numbers(40, 57);
    test_random_numbers(40, 37);
    if (verdict_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Time limit for the run; the worst case is every number a large prime.
  initial begin
    #400_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
